>>> src/pgam_pkg.sv
// shared types and constants of the per-id growth alert monitor
package pgam_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_OWN_ID           = 3'd0;
    localparam logic [2:0] CFG_PAGE_SIZE_KB     = 3'd1;
    localparam logic [2:0] CFG_COUNT_JUMP_LIMIT = 3'd2;
    localparam logic [2:0] CFG_LARGE_SIZE_MB    = 3'd3;
    localparam logic [2:0] CFG_GROWTH_LIMIT_MB  = 3'd4;
    localparam logic [2:0] CFG_HIGH_FLOOR_MB    = 3'd5;
    localparam logic [2:0] CFG_BASELINE_FACTOR  = 3'd6;
    localparam logic [2:0] CFG_BASELINE_SAMPLES = 3'd7;

    // alert kinds
    localparam logic [1:0] ALERT_COUNT_JUMP = 2'd0;
    localparam logic [1:0] ALERT_NEW_LARGE  = 2'd1;
    localparam logic [1:0] ALERT_GROWTH     = 2'd2;
    localparam logic [1:0] ALERT_HIGH_USAGE = 2'd3;

    // reset values of the configuration registers
    localparam logic [15:0] RST_OWN_ID           = 16'd0;
    localparam logic [10:0] RST_PAGE_SIZE_KB     = 11'd4;
    localparam logic [15:0] RST_COUNT_JUMP_LIMIT = 16'd50;
    localparam logic [15:0] RST_LARGE_SIZE_MB    = 16'd100;
    localparam logic [15:0] RST_GROWTH_LIMIT_MB  = 16'd10;
    localparam logic [15:0] RST_HIGH_FLOOR_MB    = 16'd500;
    localparam logic [3:0]  RST_BASELINE_FACTOR  = 4'd5;
    localparam logic [3:0]  RST_BASELINE_SAMPLES = 4'd10;

    // baseline divider: 36-bit total, one quotient bit per cycle
    localparam int DIV_STEPS = 36;
    localparam int DIV_CW    = 6;

    // result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCALE,
        S_DIV,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] ident;
        logic [31:0] amount;
        logic [31:0] size_mb;
        logic [31:0] baseline_mb;
        logic        last;
    } t_result;

endpackage

>>> src/per_id_growth_alert_monitor_core.sv
// top level of the per-id growth alert monitor
//
// Input words arrive on i_valid/o_ready. A word with i_cmd low is a scan tick
// carrying i_total_count; a word with i_cmd high is a size report for i_ident.
// Alerts leave on o_valid/i_ready, one word per alert, o_last_alert high on the
// final alert caused by an input word. Configuration registers are written
// through i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data; that port
// is always ready.
// After reset the last-size table is swept to zero, one entry per cycle, over all
// TABLE_DEPTH entries; no input word is taken during the sweep.
// A scan tick's alert is queued at the accept edge.
// A size report passes through accept (with table read), scale, and decide (with
// table write-back). While the baseline is still filling, the average is
// recomputed by a bit-serial divider between the scale and decide steps.
// Alerts wait in a four-word queue; a new word is taken while it has room for
// two alerts, so a stalled receiver holds off input once three alerts wait.
module per_id_growth_alert_monitor_core #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [15:0] i_total_count,
    input  logic [15:0] i_ident,
    input  logic [31:0] i_size_pages,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_alert_kind,
    output logic [15:0] o_alert_ident,
    output logic [31:0] o_amount,
    output logic [31:0] o_size_mb,
    output logic [31:0] o_baseline_mb,
    output logic        o_last_alert,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // configuration
    logic [15:0] r_own_id;
    logic [10:0] r_page_kb;
    logic [15:0] r_jump_limit;
    logic [15:0] r_large_mb;
    logic [15:0] r_growth_mb;
    logic [15:0] r_floor_mb;
    logic [3:0]  r_factor;
    logic [3:0]  r_samples;

    // control state
    pgam_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_clr_addr;
    logic [15:0]      r_prev_count;
    logic [1:0]       r_ticks;
    logic [35:0]      r_total;
    logic [3:0]       r_seen;
    logic [31:0]      r_avg;

    // report payload
    logic [15:0] r_ident;
    logic [42:0] r_prod;
    logic [31:0] r_mb;
    logic [31:0] r_rd;

    // table
    logic [31:0] mem [TABLE_DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          mem_re;

    // result queue
    pgam_pkg::t_result r_q [pgam_pkg::Q_DEPTH];
    logic [pgam_pkg::Q_AW-1:0] r_wp, r_rp;
    logic [pgam_pkg::Q_AW:0]   r_q_cnt;

    // divider
    logic        div_start;
    logic        div_done;
    logic [31:0] div_quo;

    logic              in_acc;
    logic              tick_acc;
    logic              rep_acc;
    logic              rep_drop;
    logic              pop;
    logic              push0, push1;
    pgam_pkg::t_result e0, e1;
    logic [1:0]        push_n;

    // tick datapath
    logic [16:0] cnt_diff;
    logic        jump;

    // scale step
    logic [31:0] mb_sat;
    logic        bl_upd;
    logic [35:0] n_total;
    logic [3:0]  n_seen;

    // decide step
    logic [35:0] thr_raw;
    logic [35:0] thr;
    logic        is_large;
    logic        seen_before;
    logic        up;
    logic [31:0] d_up, d_dn, mag;
    logic        big_up, big_mag;
    logic        a_new, a_grow, a_high;
    pgam_pkg::t_result al_new, al_grow, al_high;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id     <= pgam_pkg::RST_OWN_ID;
            r_page_kb    <= pgam_pkg::RST_PAGE_SIZE_KB;
            r_jump_limit <= pgam_pkg::RST_COUNT_JUMP_LIMIT;
            r_large_mb   <= pgam_pkg::RST_LARGE_SIZE_MB;
            r_growth_mb  <= pgam_pkg::RST_GROWTH_LIMIT_MB;
            r_floor_mb   <= pgam_pkg::RST_HIGH_FLOOR_MB;
            r_factor     <= pgam_pkg::RST_BASELINE_FACTOR;
            r_samples    <= pgam_pkg::RST_BASELINE_SAMPLES;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pgam_pkg::CFG_OWN_ID:           r_own_id     <= i_cfg_data;
                pgam_pkg::CFG_PAGE_SIZE_KB:     r_page_kb    <= i_cfg_data[10:0];
                pgam_pkg::CFG_COUNT_JUMP_LIMIT: r_jump_limit <= i_cfg_data;
                pgam_pkg::CFG_LARGE_SIZE_MB:    r_large_mb   <= i_cfg_data;
                pgam_pkg::CFG_GROWTH_LIMIT_MB:  r_growth_mb  <= i_cfg_data;
                pgam_pkg::CFG_HIGH_FLOOR_MB:    r_floor_mb   <= i_cfg_data;
                pgam_pkg::CFG_BASELINE_FACTOR:  r_factor     <= i_cfg_data[3:0];
                pgam_pkg::CFG_BASELINE_SAMPLES: r_samples    <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // tick: jump alert only after a nonzero count
    assign cnt_diff = {1'b0, i_total_count} - {1'b0, r_prev_count};
    assign jump = (r_prev_count != '0) && (i_total_count > r_prev_count)
                  && (cnt_diff[15:0] > r_jump_limit);

    assign rep_drop = (i_ident == r_own_id)
                      || ({1'b0, i_ident} >= 17'(TABLE_DEPTH));

    // pages * kb / 1024, saturated to 32 bits
    assign mb_sat  = r_prod[42] ? '1 : r_prod[41:10];
    assign bl_upd  = (r_seen < r_samples);
    assign n_total = r_total + {4'b0, mb_sat};
    assign n_seen  = r_seen + 1'b1;

    assign thr_raw = {4'b0, r_avg} * {32'b0, r_factor};
    assign thr     = (thr_raw <= {20'b0, r_floor_mb}) ? {20'b0, r_floor_mb} : thr_raw;

    assign is_large    = (r_mb > {16'b0, r_large_mb});
    assign seen_before = (r_rd != '0);
    assign up          = (r_mb > r_rd);
    assign d_up        = r_mb - r_rd;
    assign d_dn        = r_rd - r_mb;
    assign mag         = up ? d_up : d_dn;
    assign big_up      = up && (d_up > {16'b0, r_growth_mb});
    assign big_mag     = (mag > {16'b0, r_growth_mb});

    assign a_new  = is_large && !seen_before && (r_ticks > 2'd1);
    assign a_grow = is_large && seen_before && big_up;
    assign a_high = ({4'b0, r_mb} > thr) && seen_before && big_mag;

    always_comb begin
        al_new  = '{kind: pgam_pkg::ALERT_NEW_LARGE, ident: r_ident, amount: '0,
                    size_mb: r_mb, baseline_mb: '0, last: !a_high};
        al_grow = '{kind: pgam_pkg::ALERT_GROWTH, ident: r_ident, amount: d_up,
                    size_mb: r_mb, baseline_mb: '0, last: !a_high};
        al_high = '{kind: pgam_pkg::ALERT_HIGH_USAGE, ident: r_ident, amount: '0,
                    size_mb: r_mb, baseline_mb: r_avg, last: 1'b1};
    end

    assign pop = o_valid && i_ready;

    always_comb begin
        n_state   = r_state;
        o_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_ident[AW-1:0];
        mem_wdata = r_mb;
        div_start = 1'b0;
        push0     = 1'b0;
        push1     = 1'b0;
        e0        = al_high;
        e1        = al_high;
        unique case (r_state)
            pgam_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
                if (r_clr_addr == AW'(TABLE_DEPTH - 1)) begin
                    n_state = pgam_pkg::S_IDLE;
                end
            end
            pgam_pkg::S_IDLE: begin
                // room for two alerts before a word is taken
                o_ready = (r_q_cnt <= (pgam_pkg::Q_AW + 1)'(pgam_pkg::Q_DEPTH - 2));
                if (i_valid && o_ready && i_cmd && !rep_drop) begin
                    n_state = pgam_pkg::S_SCALE;
                end
                e0 = '{kind: pgam_pkg::ALERT_COUNT_JUMP, ident: '0,
                       amount: {16'b0, cnt_diff[15:0]}, size_mb: '0,
                       baseline_mb: '0, last: 1'b1};
                push0 = i_valid && o_ready && !i_cmd && jump;
            end
            pgam_pkg::S_SCALE: begin
                if (bl_upd) begin
                    div_start = 1'b1;
                    n_state   = pgam_pkg::S_DIV;
                end else begin
                    n_state = pgam_pkg::S_DECIDE;
                end
            end
            pgam_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = pgam_pkg::S_DECIDE;
                end
            end
            pgam_pkg::S_DECIDE: begin
                mem_we = 1'b1;
                // size alert first, high usage after it
                if (a_new || a_grow) begin
                    e0    = a_new ? al_new : al_grow;
                    push0 = 1'b1;
                    push1 = a_high;
                end else begin
                    push0 = a_high;
                end
                n_state = pgam_pkg::S_IDLE;
            end
            default: n_state = pgam_pkg::S_CLEAR;
        endcase
    end

    assign in_acc   = i_valid && o_ready;
    assign tick_acc = in_acc && !i_cmd;
    assign rep_acc  = in_acc && i_cmd && !rep_drop;
    assign mem_re   = rep_acc;
    assign push_n   = {1'b0, push0} + {1'b0, push1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pgam_pkg::S_CLEAR;
            r_clr_addr   <= '0;
            r_prev_count <= '0;
            r_ticks      <= '0;
            r_total      <= '0;
            r_seen       <= '0;
            r_avg        <= '0;
            r_wp         <= '0;
            r_rp         <= '0;
            r_q_cnt      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == pgam_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (tick_acc) begin
                r_prev_count <= i_total_count;
                if (r_ticks < 2'd2) begin
                    r_ticks <= r_ticks + 1'b1;
                end
            end
            if (r_state == pgam_pkg::S_SCALE && bl_upd) begin
                r_total <= n_total;
                r_seen  <= n_seen;
            end
            if (r_state == pgam_pkg::S_DIV && div_done) begin
                r_avg <= div_quo;
            end
            r_wp    <= r_wp + pgam_pkg::Q_AW'(push_n);
            r_rp    <= r_rp + pgam_pkg::Q_AW'(pop);
            r_q_cnt <= r_q_cnt + (pgam_pkg::Q_AW + 1)'(push_n)
                       - (pgam_pkg::Q_AW + 1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rep_acc) begin
            r_ident <= i_ident;
            r_prod  <= {11'b0, i_size_pages} * {32'b0, r_page_kb};
        end
        if (r_state == pgam_pkg::S_SCALE) begin
            r_mb <= mb_sat;
        end
        if (push0) begin
            r_q[r_wp] <= e0;
        end
        if (push1) begin
            r_q[r_wp + 1'b1] <= e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= mem[i_ident[AW-1:0]];
        end
    end

    pgam_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_total),
        .i_divisor  (n_seen),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_valid       = (r_q_cnt != '0);
    assign o_alert_kind  = r_q[r_rp].kind;
    assign o_alert_ident = r_q[r_rp].ident;
    assign o_amount      = r_q[r_rp].amount;
    assign o_size_mb     = r_q[r_rp].size_mb;
    assign o_baseline_mb = r_q[r_rp].baseline_mb;
    assign o_last_alert  = r_q[r_rp].last;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt <= (pgam_pkg::Q_AW + 1)'(pgam_pkg::Q_DEPTH))
        else $error("result queue overflow");

    a_pair_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_alert) |-> (r_q_cnt >= (pgam_pkg::Q_AW + 1)'(2)))
        else $error("first of two alerts queued without its partner");

    a_scale_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pgam_pkg::S_SCALE)
        |=> (r_state == pgam_pkg::S_DIV || r_state == pgam_pkg::S_DECIDE))
        else $error("report left the scale step wrongly");

    a_decide_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pgam_pkg::S_DECIDE) |=> (r_state == pgam_pkg::S_IDLE && !mem_we))
        else $error("table written twice for one report");

endmodule

>>> src/pgam_div.sv
// iterative restoring divider for the baseline average
module pgam_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [35:0] i_dividend,
    input  logic [3:0]  i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic                      r_busy;
    logic                      r_done;
    logic [pgam_pkg::DIV_CW-1:0] r_cnt;
    logic [3:0]                r_rem;
    logic [35:0]               r_quo;
    logic [3:0]                r_div;

    logic [4:0] trial;
    logic       ge;
    logic [4:0] diff;
    logic [3:0] n_rem;

    assign trial = {r_rem, r_quo[35]};
    assign ge    = (trial >= {1'b0, r_div});
    assign diff  = trial - {1'b0, r_div};
    // remainder stays below the divisor, so four bits hold it
    assign n_rem = ge ? diff[3:0] : trial[3:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= pgam_pkg::DIV_CW'(pgam_pkg::DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[34:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[31:0];

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && r_cnt == pgam_pkg::DIV_CW'(pgam_pkg::DIV_STEPS - 1)))
        else $error("divider did not load its step count");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!r_busy && $past(r_busy)))
        else $error("divider done without a finished run");

endmodule
